FILE: sv/fsd_pkg.sv
`default_nettype none

package fsd_pkg;

	localparam int GRAY_W         = 8;
	localparam int CFG_W          = 11;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int LINE_WIDTH_RST = 640;
	// result queue depth, power of two, at least two
	localparam int OUT_DEPTH      = 4;

	// error shares in sixteenths
	localparam logic [2:0] K_RIGHT       = 3'd7;
	localparam logic [2:0] K_BELOW_LEFT  = 3'd3;
	localparam logic [2:0] K_BELOW       = 3'd5;
	localparam logic [2:0] K_BELOW_RIGHT = 3'd1;

	typedef struct packed {
		logic [GRAY_W-1:0] gray;
		logic              action;
	} fsd_in_t;

	typedef struct packed {
		logic white;
		logic row_end;
		logic frame_end;
		logic last;
	} fsd_out_t;

	// quantization error: v - 255 when white, else v
	function automatic logic signed [8:0] err_of(input logic [GRAY_W-1:0] v);
		logic signed [8:0] ext;
		ext = $signed({1'b0, v});
		return v[GRAY_W-1] ? (ext - 9'sd255) : ext;
	endfunction

	// floor((16v + k*e) / 16), clamped to 0..255
	function automatic logic [GRAY_W-1:0] add_share(input logic [GRAY_W-1:0] v,
	                                               input logic [2:0] k,
	                                               input logic signed [8:0] e);
		logic signed [13:0] ke;
		logic signed [13:0] t;
		logic [8:0]         q;
		ke = 14'(e) * 14'($signed({1'b0, k}));
		t  = $signed({2'b00, v, 4'b0000}) + ke;
		q  = t[12:4];
		if (t[13])
			return '0;
		else if (q[8])
			return '1;
		else
			return q[7:0];
	endfunction

endpackage

`default_nettype wire

FILE: sv/fsd_line_ram.sv
`default_nettype none

module fsd_line_ram #(
	parameter int AW = 11
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [fsd_pkg::GRAY_W-1:0] wdata,
	input  wire logic [AW-1:0]             raddr,
	output logic      [fsd_pkg::GRAY_W-1:0] rdata
);
	import fsd_pkg::*;

	logic [GRAY_W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-through when the same entry is read and written in one cycle
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/fsd_out_fifo.sv
`default_nettype none

module fsd_out_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_one,
	input  wire logic             push_two,
	input  wire fsd_pkg::fsd_out_t push_d0,
	input  wire fsd_pkg::fsd_out_t push_d1,
	output logic                  room_two,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output fsd_pkg::fsd_out_t     res
);
	import fsd_pkg::*;

	localparam int PW = $clog2(OUT_DEPTH);

	fsd_out_t      slot_q [OUT_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   cnt_q;
	logic [PW:0]   n_push;
	logic          pop;

	assign pop       = res_valid & res_ready;
	assign res_valid = (cnt_q != '0);
	assign res       = slot_q[rd_ptr_q];
	assign room_two  = (cnt_q <= (PW+1)'(OUT_DEPTH - 2));
	assign n_push    = (PW+1)'(push_one) + (PW+1)'(push_two);

	always_ff @(posedge clk) begin
		if (push_one) begin
			slot_q[wr_ptr_q] <= push_d0;
		end
		if (push_two) begin
			slot_q[wr_ptr_q + PW'(1)] <= push_d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[PW-1:0];
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			cnt_q    <= cnt_q + n_push - (PW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: sv/floyd_steinberg_dither.sv
// floyd-steinberg error diffusion of an 8-bit gray pixel stream
//
// pix channel (valid/ready): one gray pixel per beat in raster order, action
// high marks a padding pixel; after the last image row feed one row of
// padding to flush it. res channel (valid/ready): one black/white pixel per
// beat, with row_end, frame_end and last flags.
// row r comes out while row r+1 goes in, one column behind; each result
// is registered in the result queue on the beat that produced it.
// throughput: one pixel per clock at every width, set by the single read and
// single write port of the line store; from a width of two up the row-end beat
// makes two results and the first beat of a row none, which a four-entry
// result queue absorbs. pix_ready falls only while the queue lacks room for two.
// cfg_wr_en writes line_width and restarts the frame.
// reset: column and row state clear, width goes to 640; the line store keeps
// its contents and needs no clearing pass. a stalled receiver fills the
// result queue, then holds off pix_ready; nothing is lost.
`default_nettype none

module floyd_steinberg_dither #(
	parameter int MAX_WIDTH = fsd_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [fsd_pkg::CFG_W-1:0] cfg_wr_data,
	input  wire logic                      pix_valid,
	output logic                           pix_ready,
	input  wire fsd_pkg::fsd_in_t          pix,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output fsd_pkg::fsd_out_t              res
);
	import fsd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int AW = CW + 1;
	localparam int RST_W = (LINE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : LINE_WIDTH_RST;
	localparam logic [CW-1:0] RST_LAST = CW'(RST_W - 1);

	// control state
	logic [CW-1:0] col_q, col_d;
	logic [CW-1:0] last_col_q, last_col_d;
	logic          bank_q, bank_d;      // bank holding the row being dithered
	logic          have_row_q, have_row_d;

	// datapath registers
	logic [GRAY_W-1:0] cur_upd_q;       // current row at col-1, right share applied
	logic [GRAY_W-1:0] p0_q, p1_q;      // next row at col-2 and col-1, in flight
	logic [GRAY_W-1:0] tail0_q, tail1_q; // last two columns of the finished row

	logic [GRAY_W-1:0] rd_data;
	logic              pix_acc;
	logic              at_end, first_col;
	logic [CW-1:0]     last_col_m1;
	logic [CW-1:0]     cfg_last;
	logic [GRAY_W-1:0] cur_orig, cur_c;
	logic [GRAY_W-1:0] g_in, new_c, p1_a, p0_fin, tail0_d, tail1_d;
	logic signed [8:0] e_a, e_b;
	logic              a_act, b_act, below_a, below_b;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	fsd_out_t          res_a, res_b, push_d0;
	logic              push_one, push_two;
	logic              room_two;

	assign pix_ready   = room_two;
	assign pix_acc     = pix_valid & pix_ready;
	assign at_end      = (col_q == last_col_q);
	assign first_col   = (col_q == '0);
	assign last_col_m1 = last_col_q - CW'(1);

	// width 0 acts as 1, widths past the store depth are clamped
	always_comb begin
		if (cfg_wr_data == '0) begin
			cfg_last = '0;
		end else if (32'(cfg_wr_data) > 32'(MAX_WIDTH)) begin
			cfg_last = CW'(MAX_WIDTH - 1);
		end else begin
			cfg_last = CW'(32'(cfg_wr_data) - 32'd1);
		end
	end

	// the two last columns of a row never reach the store, they live in tail regs
	always_comb begin
		if (at_end) begin
			cur_orig = tail1_q;
		end else if ((col_q == last_col_m1) && (last_col_q != '0)) begin
			cur_orig = tail0_q;
		end else begin
			cur_orig = rd_data;
		end
	end

	// dither of col-1: error goes right into the current row and below
	assign a_act   = have_row_q & ~first_col;
	assign e_a     = err_of(cur_upd_q);
	assign below_a = a_act & ~pix.action;
	assign g_in    = pix.action ? '0 : pix.gray;

	assign cur_c  = a_act   ? add_share(cur_orig, K_RIGHT, e_a)    : cur_orig;
	assign new_c  = below_a ? add_share(g_in, K_BELOW_RIGHT, e_a)  : g_in;
	assign p1_a   = below_a ? add_share(p1_q, K_BELOW, e_a)        : p1_q;
	assign p0_fin = below_a ? add_share(p0_q, K_BELOW_LEFT, e_a)   : p0_q;

	// dither of the last column on the row-end beat
	assign b_act   = have_row_q & at_end;
	assign e_b     = err_of(cur_c);
	assign below_b = b_act & ~pix.action;

	assign tail0_d = below_b ? add_share(p1_a, K_BELOW_LEFT, e_b) : p1_a;
	assign tail1_d = below_b ? add_share(new_c, K_BELOW, e_b)     : new_c;

	// next-row entry col-2 has all its shares now
	assign mem_we    = pix_acc & (col_q > CW'(1));
	assign mem_waddr = {~bank_q, col_q - CW'(2)};

	always_comb begin
		col_d      = col_q;
		bank_d     = bank_q;
		have_row_d = have_row_q;
		last_col_d = last_col_q;
		if (cfg_wr_en) begin
			col_d      = '0;
			have_row_d = 1'b0;
			last_col_d = cfg_last;
		end else if (pix_acc) begin
			if (at_end) begin
				col_d      = '0;
				bank_d     = ~bank_q;
				have_row_d = ~pix.action;
			end else begin
				col_d = col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			bank_q     <= 1'b0;
			have_row_q <= 1'b0;
			last_col_q <= RST_LAST;
		end else begin
			col_q      <= col_d;
			bank_q     <= bank_d;
			have_row_q <= have_row_d;
			last_col_q <= last_col_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			if (at_end) begin
				tail0_q <= tail0_d;
				tail1_q <= tail1_d;
			end else begin
				cur_upd_q <= cur_c;
				p0_q      <= p1_a;
				p1_q      <= new_c;
			end
		end
	end

	// read address follows the next column, so read data lines up with col_q
	fsd_line_ram #(
		.AW(AW)
	) u_line_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (p0_fin),
		.raddr ({bank_d, col_d}),
		.rdata (rd_data)
	);

	always_comb begin
		res_a           = '0;
		res_a.white     = cur_upd_q[GRAY_W-1];
		res_a.last      = ~at_end;
		res_b           = '0;
		res_b.white     = cur_c[GRAY_W-1];
		res_b.row_end   = 1'b1;
		res_b.frame_end = pix.action;
		res_b.last      = 1'b1;
	end

	assign push_one = pix_acc & (a_act | b_act);
	assign push_two = pix_acc & a_act & b_act;
	assign push_d0  = a_act ? res_a : res_b;

	fsd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_one  (push_one),
		.push_two  (push_two),
		.push_d0   (push_d0),
		.push_d1   (res_b),
		.room_two  (room_two),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// column never runs past the configured row
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= last_col_q)
		else $error("column beyond row width");

	// two results only on a row-end beat
	a_two_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		push_two |-> (at_end && push_one))
		else $error("double result away from row end");

	// a padding row end leaves no row to dither
	a_pad_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && at_end && pix.action && !cfg_wr_en) |=> !have_row_q)
		else $error("row kept after padding row");

	// frame end comes only with a row end, which closes its beat group
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.frame_end) |-> (res.row_end && res.last))
		else $error("frame end without row end");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import fsd_pkg::*;

	localparam int LINE_MAX    = MAX_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYC  = 8;
	localparam int PHASE_PIX   = 115;

	// tracks the dithering of the pixel stream and the black/white pixels still owed
	class dither_tracker;
		logic [GRAY_W-1:0] cur_line [LINE_MAX];
		logic [GRAY_W-1:0] nxt_line [LINE_MAX];
		int unsigned       col;
		bit                row_loaded;
		logic [CFG_W-1:0]  width_reg;
		fsd_out_t          due_pixels [$];
		int unsigned       errors;

		function new();
			foreach (cur_line[i]) begin
				cur_line[i] = '0;
				nxt_line[i] = '0;
			end
			col        = 0;
			row_loaded = 0;
			width_reg  = CFG_W'(LINE_WIDTH_RST);
			errors     = 0;
		endfunction

		function int line_len();
			if (width_reg == 0)
				return 1;
			if (width_reg > LINE_MAX)
				return LINE_MAX;
			return int'(width_reg);
		endfunction

		function void set_width(logic [CFG_W-1:0] v);
			width_reg  = v;
			col        = 0;
			row_loaded = 0;
		endfunction

		function int outstanding();
			return due_pixels.size();
		endfunction

		// v + k/16 of the error, floored, clamped to 0..255
		function logic [GRAY_W-1:0] spread(logic [GRAY_W-1:0] v, int k, int e);
			int t;
			t = 16 * int'(v) + k * e;
			if (t < 0)
				return '0;
			t = t / 16;
			if (t > 255)
				return '1;
			return t[GRAY_W-1:0];
		endfunction

		function void dither_col(int x, int w, bit pad, bit rend, bit tail);
			int       v;
			int       e;
			bit       wh;
			bit       has_right;
			fsd_out_t o;
			v         = int'(cur_line[x]);
			wh        = v >= 128;
			e         = wh ? v - 255 : v;
			has_right = (x + 1) < w;
			if (has_right)
				cur_line[x+1] = spread(cur_line[x+1], int'(K_RIGHT), e);
			// a padding beat sends nothing into the row below
			if (!pad) begin
				if (x >= 1)
					nxt_line[x-1] = spread(nxt_line[x-1], int'(K_BELOW_LEFT), e);
				nxt_line[x] = spread(nxt_line[x], int'(K_BELOW), e);
				if (has_right)
					nxt_line[x+1] = spread(nxt_line[x+1], int'(K_BELOW_RIGHT), e);
			end
			o.white     = wh;
			o.row_end   = rend;
			o.frame_end = rend && pad;
			o.last      = tail;
			due_pixels.push_back(o);
		endfunction

		function void take_pixel(fsd_in_t p);
			int w;
			int c;
			bit pad;
			bit at_end;
			w      = line_len();
			c      = int'(col);
			pad    = p.action;
			if (c >= w)
				c = w - 1;
			at_end = (c + 1) == w;
			nxt_line[c] = pad ? '0 : p.gray;
			if (row_loaded) begin
				if (c >= 1)
					dither_col(c - 1, w, pad, 1'b0, !at_end);
				if (at_end)
					dither_col(c, w, pad, 1'b1, 1'b1);
			end
			if (at_end) begin
				cur_line   = nxt_line;
				row_loaded = !pad;
				col        = 0;
			end else begin
				col = c + 1;
			end
		endfunction

		function void match_pixel(fsd_out_t got);
			fsd_out_t want;
			if (due_pixels.size() == 0) begin
				$error("result beat with none owed: white=%0b row_end=%0b frame_end=%0b last=%0b",
				       got.white, got.row_end, got.frame_end, got.last);
				errors++;
				return;
			end
			want = due_pixels.pop_front();
			if (got.white !== want.white) begin
				$error("white: expected %0b, got %0b", want.white, got.white);
				errors++;
			end
			if (got.row_end !== want.row_end) begin
				$error("row_end: expected %0b, got %0b", want.row_end, got.row_end);
				errors++;
			end
			if (got.frame_end !== want.frame_end) begin
				$error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;
	logic             pix_valid   = 1'b0;
	logic             pix_ready;
	fsd_in_t          pix         = '0;
	logic             res_valid;
	logic             res_ready   = 1'b0;
	fsd_out_t         res;

	dither_tracker tracker = new();

	// sender and receiver idle odds in percent; zero means a clean stretch
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	// set by the sender, served by the receiver: one long hold-off of res_ready
	bit          hold_req    = 0;
	int          line_px     = LINE_WIDTH_RST;
	int          pixels_sent = 0;
	int unsigned cycles      = 0;

	floyd_steinberg_dither u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.pix         (pix),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	always #1 clk = ~clk;

	// watchdog: a hung handshake or a lost result ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: checks every accepted result beat, stalls in random bursts
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && res_ready)
				tracker.match_pixel(res);
			if (hold_req) begin
				// long hold-off while the sender keeps offering, so the block fills up
				hold_req = 0;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_ready <= 1'b1;
			end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				res_ready <= 1'b1;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// all tasks below start and return just after a rising edge

	task automatic send_pixel(logic [GRAY_W-1:0] g, logic act);
		fsd_in_t p;
		p.gray   = g;
		p.action = act;
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= p;
		do
			@(posedge clk);
		while (!pix_ready);
		// beat accepted at this edge
		tracker.take_pixel(p);
		pixels_sent++;
	endtask

	// sender goes quiet until every owed result is back, then lets the pipe empty
	task automatic drain();
		pix_valid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_width(logic [CFG_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		tracker.set_width(v);
		line_px = tracker.line_len();
		cfg_wr_en <= 1'b0;
	endtask

	// skewed toward the threshold and the rails
	function automatic logic [GRAY_W-1:0] pick_gray();
		case ($urandom_range(0, 9))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'($urandom_range(126, 129));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int pick_idle();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 5;
			default: return 15;
		endcase
	endfunction

	// image rows then one padding row; noisy frames mix actions, some drop the padding
	task automatic run_frame(int rows, bit noisy);
		bit skip_pad;
		skip_pad = noisy && ($urandom_range(0, 3) == 0);
		for (int r = 0; r < rows; r++)
			for (int c = 0; c < line_px; c++)
				send_pixel(pick_gray(), noisy ? ($urandom_range(0, 4) == 0) : 1'b0);
		if (!skip_pad)
			for (int c = 0; c < line_px; c++)
				send_pixel(8'($urandom), noisy ? ($urandom_range(0, 4) != 0) : 1'b1);
	endtask

	task automatic run_phase(logic [CFG_W-1:0] wv);
		int start;
		int rows;
		drain();
		write_width(wv);
		start = pixels_sent;
		while (pixels_sent - start < PHASE_PIX) begin
			rows = (line_px <= 4) ? $urandom_range(1, 8) : $urandom_range(1, 3);
			run_frame(rows, $urandom_range(0, 5) == 0);
			// now and then the sender waits for the block to empty
			if ($urandom_range(0, 3) == 0)
				drain();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rails and threshold, four columns
		write_width(11'd4);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd128, 1'b0);
		send_pixel(8'd127, 1'b0);
		// padding beat in the middle of an image row, row still ends on image
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd200, 1'b1);
		send_pixel(8'd255, 1'b0);
		// flush row, frame_end on its last beat
		send_pixel(8'hff, 1'b1);
		send_pixel(8'h00, 1'b1);
		send_pixel(8'haa, 1'b1);
		send_pixel(8'h55, 1'b1);
		// padding with no row loaded produces nothing
		send_pixel(8'h5a, 1'b1);
		send_pixel(8'ha5, 1'b1);
		drain();
		// zero width behaves as one column, one result per beat once a row is loaded
		write_width(11'd0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd128, 1'b0);
		send_pixel(8'd127, 1'b0);
		send_pixel(8'd9, 1'b1);
		drain();
		// width change part way through a row restarts the frame
		write_width(11'd3);
		send_pixel(8'd17, 1'b0);
		send_pixel(8'd240, 1'b0);
		drain();
		write_width(11'd2);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd0, 1'b1);

		// random frames over several widths and idle mixes
		for (int ph = 0; ph < 6; ph++) begin
			tx_idle_pct = pick_idle();
			rx_idle_pct = pick_idle();
			case (ph)
				0:       run_phase(11'd2);
				1:       run_phase(11'd1);
				2:       run_phase(11'd5);
				3:       run_phase(11'($urandom_range(6, 16)));
				4:       run_phase(11'($urandom_range(3, 40)));
				default: run_phase(11'($urandom_range(17, 64)));
			endcase
		end

		// all-ones width clamps to the store depth, a partial row then a restart
		tx_idle_pct = 5;
		rx_idle_pct = 5;
		drain();
		write_width(11'h7ff);
		for (int c = 0; c < 40; c++)
			send_pixel(pick_gray(), 1'b0);

		// long receiver hold-off while the sender keeps offering pixels
		drain();
		write_width(11'd16);
		for (int c = 0; c < 3 * line_px; c++) begin
			if (c == 20)
				hold_req = 1;
			send_pixel(pick_gray(), c >= 2 * line_px);
		end

		// closing stretch with no idling on either side
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase(11'($urandom_range(2, 12)));

		pix_valid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
sv/fsd_pkg.sv
sv/fsd_line_ram.sv
sv/fsd_out_fifo.sv
sv/floyd_steinberg_dither.sv
sim/tb_top.sv
